>>> hw/rtl/rpcs_pkg.sv
// rpcs_pkg: widths, fixed-point constants, stage counts and constant-table
// functions for the rotary position cosine/sine pipeline
// depends on nothing; every rpcs_* module imports it
package rpcs_pkg;

    // build options
    localparam int FRAME_BITS    = 16;
    localparam int OUT_BITS      = 16;
    localparam int CORDIC_STAGES = 16;

    // field widths
    localparam int FRAME_W = 16;
    localparam int PAIR_W  = 7;
    localparam int BASE_W  = 20;
    localparam int HDIM_W  = 8;
    localparam int CFG_W   = 20;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((FRAME_W + PAIR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * OUT_BITS + 7) / 8) * 8;

    // log2 of the base, unsigned q5.24
    localparam int LOG_FRAC = 24;
    localparam int LOG_INT  = 5;
    localparam int LOG_W    = LOG_INT + LOG_FRAC;
    localparam int CNT_W    = $clog2(LOG_FRAC);

    // pair times log2, then long division by half_dim
    localparam int NUM_W = PAIR_W + LOG_W;
    localparam int REM_W = HDIM_W;

    // inverse frequency q.32 and root table entries
    localparam int ROM_LEN = 24;
    localparam int INV_W   = 33;
    localparam int ROOT_W  = 32;

    // angle product and reduction modulo two pi
    localparam int TURN_W     = 35;
    localparam int ANG_W      = FRAME_BITS + INV_W;
    localparam int MOD_STAGES = ANG_W - TURN_W + 1;
    localparam logic [TURN_W-1:0] TWO_PI_Q32  = 35'h6487ED511;
    localparam logic [TURN_W-1:0] PI_Q32      = 35'h3243F6A88;
    localparam logic [TURN_W-1:0] HALF_PI_Q32 = 35'h1921FB544;
    localparam longint QUARTER_PI_Q32 = 64'sd3373259426;

    // rotation datapath
    localparam int Z_W      = 36;
    localparam int XY_W     = 34;
    localparam int SHIFT_W  = 5;
    localparam int CORDIC_N = (CORDIC_STAGES < ROM_LEN) ? CORDIC_STAGES : ROM_LEN;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FREQ_BASE = 1'b0,
        CFG_HALF_DIM  = 1'b1
    } cfg_index_t;

    // control that travels alongside each stage
    typedef struct packed {
        logic                  valid;
        logic                  err;
        logic [FRAME_BITS-1:0] frame;
    } side_t;

    // integer square root, bit pair at a time
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_m;
        int          j;
        v     = v_in;
        res   = 64'd0;
        bit_m = 64'd1 << 62;
        for (j = 0; j < 32; j++)
        begin
            if (bit_m > v)
                bit_m = bit_m >> 2;
        end
        for (j = 0; j < 32; j++)
        begin
            if (bit_m != 64'd0)
            begin
                if (v >= res + bit_m)
                begin
                    v   = v - (res + bit_m);
                    res = (res >> 1) + bit_m;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_m = bit_m >> 2;
            end
        end
        return res;
    endfunction

    // restoring shift-subtract quotient, for table building only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        logic [63:0] q;
        int          j;
        r = 64'd0;
        q = 64'd0;
        for (j = 63; j >= 0; j--)
        begin
            r = {r[62:0], a[j]};
            if (r >= b)
            begin
                r    = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2^(-2^-m) in q0.32, by repeated square roots
    function automatic logic [ROOT_W-1:0] root_q32(input int m);
        logic [63:0] r;
        int          i;
        r = isqrt64(64'd1 << 63);
        for (i = 2; i <= m; i++)
            r = isqrt64(r << 32);
        return r[ROOT_W-1:0];
    endfunction

    // arctan(2^-i) in q.32 from the odd power series
    function automatic longint atan_q32(input int i);
        longint sum;
        longint t;
        int     n;
        int     sh;
        sum = 0;
        if (i == 0)
            return QUARTER_PI_Q32;
        for (n = 0; n < 64; n++)
        begin
            sh = 60 - i * (2 * n + 1);
            if (sh >= 0)
            begin
                t   = longint'(udiv64(64'd1 << sh, 64'(2 * n + 1)));
                sum = (n % 2 == 1) ? sum - t : sum + t;
            end
        end
        return (sum + (64'sd1 <<< 27)) >>> 28;
    endfunction

    // reciprocal of the rotation gain, q2.30
    function automatic longint gain_q30();
        logic [63:0] p;
        logic [63:0] s;
        int          i;
        p = 64'd1 << 61;
        for (i = 0; i < CORDIC_STAGES; i++)
        begin
            if (2 * i < 62)
                p = p + (p >> (2 * i));
        end
        s = isqrt64(p >> 1);
        return longint'(udiv64(64'd1 << 60, s));
    endfunction

endpackage

>>> hw/rtl/rotary_position_cos_sin.sv
// Rotary position cosine/sine table. Each request carries a frame index and a
// pair index; the result is cos and sin of frame * base^(-pair/half_dim) in
// signed Q1.15, or zeros with the error flag when the pair is not below
// half_dim. The pipeline takes one request per clock while s_tready is high;
// with the default build it has 29 division cells, 24 exponent cells, 15
// reduction cells and 16 rotation cells plus six single stages. The whole
// chain holds while a result waits on a low m_tready. After reset and after
// every freq_base write, s_tready stays low while the log2 unit recomputes
// log2 of the base, by its squaring loop for bases above one; half_dim
// writes take effect at once.
// depends on rpcs_pkg and the rpcs_* cells
module rotary_position_cos_sin (
    input  logic                             clk,
    input  logic                             rst_n,
    // frame_index [15:0], pair_index [22:16], zero padding above
    input  logic [rpcs_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cos_value [15:0], sin_value [31:16]
    output logic [rpcs_pkg::OUT_DATA_W-1:0]  m_tdata,
    // range_error [0]
    output logic                             m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  rpcs_pkg::cfg_index_t             cfg_index,
    input  logic [rpcs_pkg::CFG_W-1:0]       cfg_data
);
    import rpcs_pkg::*;

    localparam int SH    = 31 - OUT_BITS;
    localparam int RND_W = XY_W + 1;
    localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'((64'sd1 <<< (OUT_BITS - 1)) - 1);
    localparam logic signed [RND_W-1:0] OUT_MIN = RND_W'(-(64'sd1 <<< (OUT_BITS - 1)));
    localparam logic signed [Z_W-1:0] TWO_PI_Z  = Z_W'(TWO_PI_Q32);
    localparam logic signed [Z_W-1:0] PI_Z      = Z_W'(PI_Q32);
    localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(HALF_PI_Q32);
    localparam logic signed [XY_W-1:0] GAIN     = XY_W'(gain_q30());

    // configuration registers
    logic [BASE_W-1:0]    freq_base_reg;
    logic [HDIM_W-1:0]    half_dim_reg;
    logic                 cfg_write;
    logic                 log_done;
    logic [LOG_W-1:0]     log_value;

    // pipeline control
    logic                 adv;
    logic                 take;

    // single stages
    side_t                a_side_reg;
    logic [PAIR_W-1:0]    a_pair_reg;
    side_t                b_side_reg;
    logic [NUM_W-1:0]     b_num_reg;
    side_t                s_side_reg;
    logic [INV_W-1:0]     s_inv_reg;
    side_t                m_side_reg;
    logic [ANG_W-1:0]     m_ang_reg;
    side_t                f_side_reg;
    logic                 f_neg_reg;
    logic signed [Z_W-1:0] f_z_reg;
    logic signed [Z_W-1:0] z_wrap;
    logic signed [Z_W-1:0] z_fold;
    logic                 neg_fold;
    logic                 out_valid_reg;
    logic                 out_err_reg;
    logic [OUT_BITS-1:0]  out_cos_reg;
    logic [OUT_BITS-1:0]  out_sin_reg;
    logic signed [XY_W-1:0] x_fin;
    logic signed [XY_W-1:0] y_fin;

    // cell chains
    side_t                 div_side [0:LOG_W];
    logic [REM_W-1:0]      div_rem  [0:LOG_W];
    logic [LOG_W-1:0]      div_low  [0:LOG_W];
    logic [LOG_W-1:0]      div_quo  [0:LOG_W];
    side_t                 exp_side [0:ROM_LEN];
    logic [LOG_W-1:0]      exp_expo [0:ROM_LEN];
    logic [INV_W-1:0]      exp_inv  [0:ROM_LEN];
    side_t                 mod_side [0:MOD_STAGES];
    logic [ANG_W-1:0]      mod_ang  [0:MOD_STAGES];
    side_t                 cor_side [0:CORDIC_N];
    logic                  cor_neg  [0:CORDIC_N];
    logic signed [XY_W-1:0] cor_x   [0:CORDIC_N];
    logic signed [XY_W-1:0] cor_y   [0:CORDIC_N];
    logic signed [Z_W-1:0]  cor_z   [0:CORDIC_N];

    // round half up and saturate to the output range
    function automatic logic [OUT_BITS-1:0] out_word(input logic signed [XY_W-1:0] v);
        logic signed [RND_W-1:0] q;
        q = (RND_W'(v) + RND_W'(64'sd1 <<< (SH - 1))) >>> SH;
        if (q > OUT_MAX)
            q = OUT_MAX;
        if (q < OUT_MIN)
            q = OUT_MIN;
        return q[OUT_BITS-1:0];
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_base_reg <= BASE_W'(10000);
            half_dim_reg  <= HDIM_W'(64);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FREQ_BASE: freq_base_reg <= cfg_data[BASE_W-1:0];
                CFG_HALF_DIM:  half_dim_reg  <= cfg_data[HDIM_W-1:0];
                default:       half_dim_reg  <= half_dim_reg;
            endcase
        end
    end

    rpcs_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_write && (cfg_index == CFG_FREQ_BASE)),
        .base      (freq_base_reg),
        .done      (log_done),
        .log_value (log_value)
    );

    // chain advances whenever the output register is free or being taken
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && log_done;
    assign take     = s_tvalid && s_tready;

    // input stage and range check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg <= '0;
            b_side_reg <= '0;
        end
        else if (adv)
        begin
            a_side_reg.valid <= take;
            a_side_reg.err   <= ({1'b0, s_tdata[FRAME_W +: PAIR_W]} >= half_dim_reg);
            a_side_reg.frame <= FRAME_BITS'(s_tdata[FRAME_W-1:0]);
            b_side_reg       <= a_side_reg;
        end
    end

    // pair times log2 of the base
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_pair_reg <= s_tdata[FRAME_W +: PAIR_W];
            b_num_reg  <= a_pair_reg * log_value;
        end
    end

    // division by half_dim
    assign div_side[0] = b_side_reg;
    assign div_rem[0]  = REM_W'(b_num_reg[NUM_W-1:LOG_W]);
    assign div_low[0]  = b_num_reg[LOG_W-1:0];
    assign div_quo[0]  = '0;

    for (genvar g = 0; g < LOG_W; g++)
    begin : g_div
        rpcs_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .divisor (half_dim_reg),
            .side_i  (div_side[g]),
            .rem_i   (div_rem[g]),
            .low_i   (div_low[g]),
            .quo_i   (div_quo[g]),
            .side_o  (div_side[g+1]),
            .rem_o   (div_rem[g+1]),
            .low_o   (div_low[g+1]),
            .quo_o   (div_quo[g+1])
        );
    end

    // fractional power of two from the root table
    assign exp_side[0] = div_side[LOG_W];
    assign exp_expo[0] = div_quo[LOG_W];
    assign exp_inv[0]  = INV_W'(64'd1 << 32);

    for (genvar g = 0; g < ROM_LEN; g++)
    begin : g_exp
        localparam logic [ROOT_W-1:0] ROOT = root_q32(g + 1);
        rpcs_exp_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv),
            .root   (ROOT),
            .apply  (exp_expo[g][LOG_FRAC-1-g]),
            .side_i (exp_side[g]),
            .expo_i (exp_expo[g]),
            .inv_i  (exp_inv[g]),
            .side_o (exp_side[g+1]),
            .expo_o (exp_expo[g+1]),
            .inv_o  (exp_inv[g+1])
        );
    end

    // integer part of the exponent as a shift, then the angle product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_side_reg <= '0;
            m_side_reg <= '0;
        end
        else if (adv)
        begin
            s_side_reg <= exp_side[ROM_LEN];
            m_side_reg <= s_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_inv_reg  <= exp_inv[ROM_LEN] >> exp_expo[ROM_LEN][LOG_W-1:LOG_FRAC];
            m_ang_reg  <= ANG_W'(s_side_reg.frame) * ANG_W'(s_inv_reg);
        end
    end

    // reduction modulo two pi, largest multiple first
    assign mod_side[0] = m_side_reg;
    assign mod_ang[0]  = m_ang_reg;

    for (genvar g = 0; g < MOD_STAGES; g++)
    begin : g_mod
        localparam logic [ANG_W-1:0] MODV = ANG_W'(TWO_PI_Q32) << (MOD_STAGES - 1 - g);
        rpcs_mod_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .modulus (MODV),
            .side_i  (mod_side[g]),
            .ang_i   (mod_ang[g]),
            .side_o  (mod_side[g+1]),
            .ang_o   (mod_ang[g+1])
        );
    end

    // wrap to the signed range and fold into plus or minus half pi
    always_comb
    begin
        z_wrap   = $signed({1'b0, mod_ang[MOD_STAGES][TURN_W-1:0]});
        if (z_wrap > PI_Z)
            z_wrap = z_wrap - TWO_PI_Z;
        z_fold   = z_wrap;
        neg_fold = 1'b0;
        if (z_wrap > HALF_PI_Z)
        begin
            z_fold   = z_wrap - PI_Z;
            neg_fold = 1'b1;
        end
        else if (z_wrap < -HALF_PI_Z)
        begin
            z_fold   = z_wrap + PI_Z;
            neg_fold = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_side_reg <= '0;
        else if (adv)
            f_side_reg <= mod_side[MOD_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_z_reg   <= z_fold;
            f_neg_reg <= neg_fold;
        end
    end

    // rotation chain
    assign cor_side[0] = f_side_reg;
    assign cor_neg[0]  = f_neg_reg;
    assign cor_x[0]    = GAIN;
    assign cor_y[0]    = '0;
    assign cor_z[0]    = f_z_reg;

    for (genvar g = 0; g < CORDIC_N; g++)
    begin : g_cordic
        localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q32(g));
        rpcs_cordic_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv),
            .shift  (SHIFT_W'(g)),
            .angle  (ATAN),
            .side_i (cor_side[g]),
            .neg_i  (cor_neg[g]),
            .x_i    (cor_x[g]),
            .y_i    (cor_y[g]),
            .z_i    (cor_z[g]),
            .side_o (cor_side[g+1]),
            .neg_o  (cor_neg[g+1]),
            .x_o    (cor_x[g+1]),
            .y_o    (cor_y[g+1]),
            .z_o    (cor_z[g+1])
        );
    end

    // sign flip for folded angles, rounding and the output register
    assign x_fin = cor_neg[CORDIC_N] ? -cor_x[CORDIC_N] : cor_x[CORDIC_N];
    assign y_fin = cor_neg[CORDIC_N] ? -cor_y[CORDIC_N] : cor_y[CORDIC_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cor_side[CORDIC_N].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_err_reg <= cor_side[CORDIC_N].err;
            out_cos_reg <= cor_side[CORDIC_N].err ? '0 : out_word(x_fin);
            out_sin_reg <= cor_side[CORDIC_N].err ? '0 : out_word(y_fin);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_err_reg;
    assign m_tdata  = OUT_DATA_W'({out_sin_reg, out_cos_reg});

endmodule

>>> hw/rtl/rpcs_log2.sv
// rpcs_log2: iterative log2 of the rope base, q5.24, by repeated squaring
// depends on rpcs_pkg
module rpcs_log2 (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rpcs_pkg::BASE_W-1:0]  base,
    output logic                         done,
    output logic [rpcs_pkg::LOG_W-1:0]   log_value
);
    import rpcs_pkg::*;

    typedef enum logic [1:0] {
        L_START,
        L_SQUARE,
        L_DONE
    } log_state_t;

    localparam int X_W = 31;

    log_state_t              state_reg, state_next;
    logic [X_W-1:0]          x_reg, x_next;
    logic [LOG_FRAC-1:0]     frac_reg, frac_next;
    logic [LOG_INT-1:0]      p_reg, p_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [LOG_W-1:0]        log_reg, log_next;

    logic [LOG_INT-1:0]      msb;
    logic [2*X_W-1:0]        sq;
    logic [X_W:0]            xs;

    // leading one of the base
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < BASE_W; i++)
        begin
            if (base[i])
                msb = LOG_INT'(i);
        end
    end

    assign sq = x_reg * x_reg;
    assign xs = sq[X_W+30:30];

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        frac_next  = frac_reg;
        p_next     = p_reg;
        cnt_next   = cnt_reg;
        log_next   = log_reg;
        case (state_reg)
            L_START:
            begin
                if (base <= BASE_W'(1))
                begin
                    log_next   = '0;
                    state_next = L_DONE;
                end
                else
                begin
                    x_next     = X_W'((51'(base) << 30) >> msb);
                    p_next     = msb;
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = L_SQUARE;
                end
            end
            L_SQUARE:
            begin
                x_next    = xs[X_W] ? xs[X_W:1] : xs[X_W-1:0];
                frac_next = {frac_reg[LOG_FRAC-2:0], xs[X_W]};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LOG_FRAC - 1))
                begin
                    log_next   = {p_reg, frac_reg[LOG_FRAC-2:0], xs[X_W]};
                    state_next = L_DONE;
                end
            end
            L_DONE:
            begin
                state_next = L_DONE;
            end
            default:
            begin
                state_next = L_START;
            end
        endcase
        if (start)
            state_next = L_START;
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_START;
            x_reg     <= '0;
            frac_reg  <= '0;
            p_reg     <= '0;
            cnt_reg   <= '0;
            log_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            frac_reg  <= frac_next;
            p_reg     <= p_next;
            cnt_reg   <= cnt_next;
            log_reg   <= log_next;
        end
    end

    assign done      = (state_reg == L_DONE);
    assign log_value = log_reg;

endmodule

>>> hw/rtl/rpcs_div_cell.sv
// rpcs_div_cell: one restoring division step, one quotient bit per cell
// depends on rpcs_pkg
module rpcs_div_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [rpcs_pkg::HDIM_W-1:0] divisor,
    input  rpcs_pkg::side_t             side_i,
    input  logic [rpcs_pkg::REM_W-1:0]  rem_i,
    input  logic [rpcs_pkg::LOG_W-1:0]  low_i,
    input  logic [rpcs_pkg::LOG_W-1:0]  quo_i,
    output rpcs_pkg::side_t             side_o,
    output logic [rpcs_pkg::REM_W-1:0]  rem_o,
    output logic [rpcs_pkg::LOG_W-1:0]  low_o,
    output logic [rpcs_pkg::LOG_W-1:0]  quo_o
);
    import rpcs_pkg::*;

    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    // bring down the next numerator bit and try the subtract
    assign trial = {rem_i, low_i[LOG_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_o <= '0;
        else if (en)
            side_o <= side_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_o <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            low_o <= {low_i[LOG_W-2:0], 1'b0};
            quo_o <= {quo_i[LOG_W-2:0], ge};
        end
    end

endmodule

>>> hw/rtl/rpcs_exp_cell.sv
// rpcs_exp_cell: one exponent bit, multiplies by its root table entry when set
// depends on rpcs_pkg
module rpcs_exp_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [rpcs_pkg::ROOT_W-1:0] root,
    input  logic                        apply,
    input  rpcs_pkg::side_t             side_i,
    input  logic [rpcs_pkg::LOG_W-1:0]  expo_i,
    input  logic [rpcs_pkg::INV_W-1:0]  inv_i,
    output rpcs_pkg::side_t             side_o,
    output logic [rpcs_pkg::LOG_W-1:0]  expo_o,
    output logic [rpcs_pkg::INV_W-1:0]  inv_o
);
    import rpcs_pkg::*;

    logic [INV_W+ROOT_W-1:0] prod;

    // truncated q.32 product
    assign prod = inv_i * root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_o <= '0;
        else if (en)
            side_o <= side_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            expo_o <= expo_i;
            inv_o  <= apply ? prod[INV_W+31:32] : inv_i;
        end
    end

endmodule

>>> hw/rtl/rpcs_mod_cell.sv
// rpcs_mod_cell: one conditional subtract of a shifted two pi
// depends on rpcs_pkg
module rpcs_mod_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [rpcs_pkg::ANG_W-1:0] modulus,
    input  rpcs_pkg::side_t            side_i,
    input  logic [rpcs_pkg::ANG_W-1:0] ang_i,
    output rpcs_pkg::side_t            side_o,
    output logic [rpcs_pkg::ANG_W-1:0] ang_o
);
    import rpcs_pkg::*;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_o <= '0;
        else if (en)
            side_o <= side_i;
    end

    // subtract when the remainder still reaches this multiple
    always_ff @(posedge clk)
    begin
        if (en)
            ang_o <= (ang_i >= modulus) ? ang_i - modulus : ang_i;
    end

endmodule

>>> hw/rtl/rpcs_cordic_cell.sv
// rpcs_cordic_cell: one rotation-mode cordic micro-rotation
// depends on rpcs_pkg
module rpcs_cordic_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [rpcs_pkg::SHIFT_W-1:0]        shift,
    input  logic signed [rpcs_pkg::Z_W-1:0]     angle,
    input  rpcs_pkg::side_t                     side_i,
    input  logic                                neg_i,
    input  logic signed [rpcs_pkg::XY_W-1:0]    x_i,
    input  logic signed [rpcs_pkg::XY_W-1:0]    y_i,
    input  logic signed [rpcs_pkg::Z_W-1:0]     z_i,
    output rpcs_pkg::side_t                     side_o,
    output logic                                neg_o,
    output logic signed [rpcs_pkg::XY_W-1:0]    x_o,
    output logic signed [rpcs_pkg::XY_W-1:0]    y_o,
    output logic signed [rpcs_pkg::Z_W-1:0]     z_o
);
    import rpcs_pkg::*;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign xs = x_i >>> shift;
    assign ys = y_i >>> shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_o <= '0;
        else if (en)
            side_o <= side_i;
    end

    // rotate towards zero residual angle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_o <= neg_i;
            if (z_i >= 0)
            begin
                x_o <= x_i - ys;
                y_o <= y_i + xs;
                z_o <= z_i - angle;
            end
            else
            begin
                x_o <= x_i + ys;
                y_o <= y_i - xs;
                z_o <= z_i + angle;
            end
        end
    end

endmodule

>>> hw/rtl/rpcs_checker.sv
// rpcs_checker: port-level assertions for rotary_position_cos_sin
// depends on rpcs_pkg; bound to the top level below
module rpcs_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rpcs_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             m_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             s_tready,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  rpcs_pkg::cfg_index_t             cfg_index
);
    import rpcs_pkg::*;

    // a pair out of range gives zero cosine and sine
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0))
    else $error("range error result with non-zero data");

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

    // a new base blocks requests while its log2 is recomputed
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == CFG_FREQ_BASE) |=> !s_tready)
    else $error("request accepted during log2 recompute");

endmodule

bind rotary_position_cos_sin rpcs_checker u_rpcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

>>> test/tb_rotary_position_cos_sin.sv
// Testbench for rotary_position_cos_sin: streams frame/pair requests, predicts
// each cos/sin result in fixed point and compares results in arrival order.
// Depends on rpcs_pkg and the rotary_position_cos_sin RTL.
module tb_rotary_position_cos_sin;
    timeunit 1ns;
    timeprecision 1ps;
    import rpcs_pkg::*;

    typedef struct {
        logic [15:0] frame;
        logic [6:0]  pair;
    } pos_request_t;

    typedef struct {
        logic [15:0] cos_v;
        logic [15:0] sin_v;
        logic        err;
    } cos_sin_t;

    localparam longint TWO_PI = 64'sd26986075409;
    localparam longint PI     = 64'sd13493037704;
    localparam longint HALF_PI = 64'sd6746518852;
    localparam int LIMIT_CYCLES = 400000;

    logic clk;
    logic rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    rotary_position_cos_sin dut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // testbench copy of the registers and constant tables
    logic [19:0]    base_reg;
    logic [7:0]     hdim_reg;
    logic [63:0]    root_tab [0:24];
    longint         atan_tab [0:23];
    longint         gain_x;

    pos_request_t   pending_requests [$];
    cos_sin_t       expected_angles [$];
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             stall_go;
    int             stall_cnt;
    bit             in_fire;
    int             mismatches;
    int             cycles;

    function automatic logic [63:0] sq_root64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_base(input logic [19:0] b);
        logic [63:0] x;
        logic [63:0] frac;
        int          p;
        frac = 0;
        p    = 0;
        if (b <= 1)
            return 0;
        while ((64'(b) >> (p + 1)) != 0)
            p++;
        x = (64'(b) << 30) >> p;
        for (int i = 0; i < 24; i++)
        begin
            x    = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd2 << 30))
            begin
                frac = frac | 1;
                x    = x >> 1;
            end
        end
        return (64'(p) << 24) | frac;
    endfunction

    // round half up to q1.15 and saturate
    function automatic logic [15:0] to_q15(input longint v);
        longint q;
        q = (v + (64'sd1 <<< 14)) >>> 15;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic cos_sin_t rotary_cos_sin(input logic [15:0] f, input logic [6:0] k);
        cos_sin_t    r;
        logic [63:0] e;
        logic [63:0] inv;
        logic [63:0] ang;
        longint      z;
        longint      x;
        longint      y;
        longint      nx;
        longint      ny;
        int          n;
        bit          flip;
        flip = 0;
        if (k >= hdim_reg)
        begin
            r.cos_v = 0;
            r.sin_v = 0;
            r.err   = 1;
            return r;
        end
        e   = (64'(k) * log2_base(base_reg)) / 64'(hdim_reg);
        n   = int'(e >> 24);
        inv = 64'd1 << 32;
        for (int m = 1; m <= 24; m++)
            if ((e >> (24 - m)) & 1)
                inv = (inv * root_tab[m]) >> 32;
        inv = (n < 64) ? (inv >> n) : 0;
        ang = (64'(f) * inv) % 64'(TWO_PI);
        z   = longint'(ang);
        if (z > PI)
            z -= TWO_PI;
        if (z > HALF_PI)
        begin
            z -= PI;
            flip = 1;
        end
        else if (z < -HALF_PI)
        begin
            z += PI;
            flip = 1;
        end
        x = gain_x;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_tab[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        r.cos_v = to_q15(x);
        r.sin_v = to_q15(y);
        r.err   = 0;
        return r;
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // request driver
    always @(posedge clk)
        in_fire <= s_tvalid && s_tready;

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, pending_requests[0].pair, pending_requests[0].frame};
                void'(pending_requests.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // prediction on each accepted request
    always @(posedge clk)
        if (s_tvalid && s_tready)
            expected_angles.push_back(rotary_cos_sin(s_tdata[15:0], s_tdata[22:16]));

    // receiver ready, with one long hold-off when asked
    always @(negedge clk)
    begin
        if (stall_cnt > 0)
        begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end
        else if (stall_go)
        begin
            stall_go  <= 1'b0;
            stall_cnt <= 600;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (expected_angles.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result cos=%h sin=%h err=%b",
                             m_tdata[15:0], m_tdata[31:16], m_tuser);
            end
            else
            begin
                if (m_tdata[15:0] !== expected_angles[0].cos_v ||
                    m_tdata[31:16] !== expected_angles[0].sin_v ||
                    m_tuser !== expected_angles[0].err)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"mismatch: expected cos=%h sin=%h err=%b, ",
                                  "got cos=%h sin=%h err=%b"},
                                 expected_angles[0].cos_v, expected_angles[0].sin_v,
                                 expected_angles[0].err, m_tdata[15:0], m_tdata[31:16],
                                 m_tuser);
                end
                void'(expected_angles.pop_front());
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [19:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_FREQ_BASE)
            base_reg = val;
        else
            hdim_reg = val[7:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [19:0] b, input logic [7:0] h);
        write_reg(CFG_FREQ_BASE, b);
        write_reg(CFG_HALF_DIM, {12'd0, h});
    endtask

    task automatic queue_request(input logic [15:0] f, input logic [6:0] k);
        pos_request_t q;
        q.frame = f;
        q.pair  = k;
        pending_requests.push_back(q);
    endtask

    // edges of both fields around the current half_dim
    task automatic queue_edges();
        logic [6:0] top;
        top = (hdim_reg == 0) ? 7'd0 : 7'(hdim_reg - 1);
        queue_request(16'd0, 7'd0);
        queue_request(16'hFFFF, 7'd0);
        queue_request(16'd1, 7'd0);
        queue_request(16'hFFFF, top);
        queue_request(16'd1, top);
        queue_request(16'h8000, top);
        queue_request(16'hFFFF, 7'd127);
        queue_request(16'd0, 7'(hdim_reg));
        queue_request(16'hAAAA, 7'h55);
        queue_request(16'h5555, 7'h2A);
    endtask

    // mostly in-range pairs, some out of range, frames small or full width
    task automatic queue_random(input int count);
        logic [15:0] f;
        logic [6:0]  k;
        for (int i = 0; i < count; i++)
        begin
            if (hdim_reg != 0 && $urandom_range(99) < 85)
                k = 7'($urandom_range(hdim_reg > 128 ? 127 : hdim_reg - 1));
            else
                k = 7'($urandom_range(127));
            f = ($urandom_range(3) == 0) ? 16'($urandom_range(15)) : 16'($urandom);
            queue_request(f, k);
        end
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_angles.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        s_tvalid  = 0;
        s_tdata   = 0;
        m_tready  = 0;
        cfg_valid = 0;
        cfg_index = CFG_FREQ_BASE;
        cfg_data  = 0;
        stall_go  = 0;
        stall_cnt = 0;
        in_fire   = 0;
        mismatches = 0;
        cycles    = 0;
        base_reg  = 20'd10000;
        hdim_reg  = 8'd64;
        send_idle_pct = 20;
        recv_idle_pct = 71;

        // constant tables
        root_tab[0] = 0;
        root_tab[1] = sq_root64(64'd1 << 63);
        for (int i = 2; i <= 24; i++)
            root_tab[i] = sq_root64(root_tab[i - 1] << 32);
        atan_tab[0] = 64'sd3373259426;
        for (int i = 1; i < 24; i++)
        begin
            longint s;
            s = 0;
            for (int n = 0; 60 - i * (2 * n + 1) >= 0; n++)
            begin
                longint t;
                t = (64'sd1 <<< (60 - i * (2 * n + 1))) / longint'(2 * n + 1);
                s = (n % 2) ? s - t : s + t;
            end
            atan_tab[i] = (s + (64'sd1 <<< 27)) >>> 28;
        end
        begin
            logic [63:0] p;
            p = 64'd1 << 61;
            for (int i = 0; i < 16; i++)
                p = p + (p >> (2 * i));
            gain_x = longint'((64'd1 << 60) / sq_root64(p >> 1));
        end

        rst_n = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset settings
        queue_edges();
        queue_random(250);
        drain();

        // base of two and half dimension of one
        set_regs(20'd2, 8'd1);
        queue_edges();
        queue_random(100);
        drain();

        // base of 1000000 with half dimension 128, sender now the slower side, with one long stall
        send_idle_pct = 71;
        recv_idle_pct = 20;
        set_regs(20'd1000000, 8'd128);
        stall_go = 1;
        queue_edges();
        queue_random(250);
        drain();

        // zero half dimension: every pair out of range
        set_regs(20'd0, 8'd0);
        queue_edges();
        queue_random(40);
        drain();

        // base below two
        set_regs(20'd1, 8'd37);
        queue_random(120);
        drain();

        // no idling, full 20-bit base, then random settings
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(20'hFFFFF, 8'd128);
        queue_random(140);
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph % 2) ? 30 : 0;
            recv_idle_pct = (ph % 3 == 1) ? 40 : 0;
            set_regs(20'($urandom_range(1000000, 2)), 8'($urandom_range(128, 1)));
            queue_random(50);
            drain();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_angles.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
